// ----- rtl/sfa_pkg.sv -----
// ----------------------------------------------------------------------------
// sfa_pkg: shared types for the segment fit allocator
// Field structs, status and command codes, sequencer states, scan control.
// ----------------------------------------------------------------------------
package sfa_pkg;

  localparam int ADDR_BITS     = 16;
  localparam int SIZE_BITS     = 17;
  localparam int UNIT_LOG2_MAX = 12;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NO_SPACE = 2'd1,
    ST_FULL     = 2'd2,
    ST_INVALID  = 2'd3
  } status_t;

  typedef enum logic {
    CMD_ALLOC = 1'b0,
    CMD_FREE  = 1'b1
  } cmd_t;

  typedef enum logic {
    FIT_BEST  = 1'b0,
    FIT_WORST = 1'b1
  } fit_t;

  localparam logic [1:0] CFG_FIT_MODE = 2'd0;
  localparam logic [1:0] CFG_UNIT_LOG2 = 2'd1;
  localparam logic [1:0] CFG_MEM_SIZE = 2'd2;

  typedef struct packed {
    logic        command;
    logic [16:0] request_bytes;
    logic [15:0] region_base;
  } in_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] granted_base;
    logic [16:0] granted_size;
  } out_t;

  typedef enum logic [2:0] {
    S_INIT,
    S_IDLE,
    S_SCAN,
    S_DECIDE,
    S_SHIFT
  } state_t;

  typedef struct packed {
    logic        clear;
    logic        chk_v;
    cmd_t        cmd;
    fit_t        fit;
    logic [17:0] need;
    logic [15:0] base;
    logic [17:0] fend;
  } scan_ctl_t;

  typedef struct packed {
    logic        found;
    logic [15:0] pick_base;
    logic [16:0] pick_size;
    logic        overlap;
    logic        left_v;
    logic [15:0] left_base;
    logic [16:0] left_size;
    logic        right_v;
    logic [15:0] right_base;
    logic [16:0] right_size;
  } scan_res_t;

endpackage

// ----- rtl/sfa_ram.sv -----
// ----------------------------------------------------------------------------
// sfa_ram: generic simple dual port RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module sfa_ram #(
  parameter int WIDTH = 33,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/sfa_scan.sv -----
// ----------------------------------------------------------------------------
// sfa_scan: per-entry compare unit for the table scan
// Track best/worst fit pick, overlap, and free neighbors over one beat each.
// ----------------------------------------------------------------------------
module sfa_scan
  import sfa_pkg::*;
#(
  parameter int IW = 6,
  parameter int CW = 7
) (
  input  logic        clk,
  input  scan_ctl_t   ctl,
  input  logic [IW-1:0] idx,
  input  logic [15:0] e_base,
  input  logic [16:0] e_size,
  output scan_res_t   res,
  output logic [CW-1:0] pick_idx,
  output logic [CW-1:0] pos
);

  scan_res_t     res_r, res_nxt;
  logic [CW-1:0] pick_idx_r, pick_idx_nxt;
  logic [CW-1:0] pos_r, pos_nxt;
  logic [17:0]   e_end;
  logic          fits, better;

  assign e_end  = {2'b0, e_base} + {1'b0, e_size};
  assign fits   = {1'b0, e_size} >= ctl.need;
  assign better = (ctl.fit == FIT_BEST) ? (e_size < res_r.pick_size)
                                        : (e_size > res_r.pick_size);

  always_comb begin
    res_nxt      = res_r;
    pick_idx_nxt = pick_idx_r;
    pos_nxt      = pos_r;
    if (ctl.clear) begin
      res_nxt.found   = 1'b0;
      res_nxt.overlap = 1'b0;
      res_nxt.left_v  = 1'b0;
      res_nxt.right_v = 1'b0;
      pos_nxt         = '0;
    end else if (ctl.chk_v) begin
      if (ctl.cmd == CMD_ALLOC) begin
        if (fits && (!res_r.found || better)) begin
          res_nxt.found     = 1'b1;
          res_nxt.pick_base = e_base;
          res_nxt.pick_size = e_size;
          pick_idx_nxt      = CW'(idx);
        end
      end else begin
        if (({2'b0, ctl.base} < e_end) && ({2'b0, e_base} < ctl.fend)) begin
          res_nxt.overlap = 1'b1;
        end
        if (e_base < ctl.base) begin
          pos_nxt           = CW'(idx) + CW'(1);
          res_nxt.left_v    = 1'b1;
          res_nxt.left_base = e_base;
          res_nxt.left_size = e_size;
        end else if (!res_r.right_v) begin
          res_nxt.right_v    = 1'b1;
          res_nxt.right_base = e_base;
          res_nxt.right_size = e_size;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    res_r      <= res_nxt;
    pick_idx_r <= pick_idx_nxt;
    pos_r      <= pos_nxt;
  end

  assign res      = res_r;
  assign pick_idx = pick_idx_r;
  assign pos      = pos_r;

endmodule

// ----- rtl/segment_fit_allocator.sv -----
// ----------------------------------------------------------------------------
// segment_fit_allocator: best/worst fit free segment allocator
// Sorted table of free segments in one RAM, scanned and shifted by a sequencer.
// ----------------------------------------------------------------------------
// Sequence: zero-size or out-of-range requests are answered from idle; others scan
//   all count entries, take a decide step and, when the entry at position k is
//   dropped or inserted, shift the entries above k down or the entries from k up
//   through the RAM's single read port.
// Throughput: one beat at a time; a scanned beat keeps busy high until its result strobe.
// Reset: synchronous active low; the init state then loads the segment (0, 65536).
// The result strobe lasts one cycle; the receiver cannot stall.
module segment_fit_allocator
  import sfa_pkg::*;
#(
  parameter int MAX_SEGMENTS = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  in_t         in_item,
  output logic        out_valid,
  output out_t        out_item,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_addr,
  input  logic [16:0] cfg_wdata
);

  localparam int IW = $clog2(MAX_SEGMENTS);
  localparam int CW = $clog2(MAX_SEGMENTS + 1);
  localparam int EW = SIZE_BITS + ADDR_BITS;
  localparam logic [16:0] SPACE = 17'h10000;

  // sequencer and configuration registers
  state_t        state_r, state_nxt;
  cmd_t          cmd_r, cmd_nxt;
  logic [15:0]   base_r, base_nxt;
  logic [17:0]   need_r, need_nxt;
  logic [17:0]   fend_r, fend_nxt;
  logic [CW-1:0] count_r, count_nxt;
  fit_t          fit_r, fit_nxt;
  logic [3:0]    unit_r, unit_nxt;
  logic [16:0]   mem_r, mem_nxt;
  logic [CW-1:0] scan_idx_r, scan_idx_nxt;
  logic          chk_v_r, chk_v_nxt;
  logic [IW-1:0] chk_idx_r, chk_idx_nxt;
  logic          sh_act_r, sh_act_nxt;
  logic          sh_up_r, sh_up_nxt;
  logic [CW-1:0] sh_idx_r, sh_idx_nxt;
  logic [CW-1:0] sh_lo_r, sh_lo_nxt;
  logic          wv_r, wv_nxt;
  logic [IW-1:0] wa_r, wa_nxt;
  logic          out_valid_r, out_valid_nxt;
  out_t          out_item_r, out_item_nxt;

  // RAM port
  logic          ram_we;
  logic [IW-1:0] ram_wa, ram_ra;
  logic [EW-1:0] ram_wd, ram_rd;

  scan_ctl_t     ctl;
  scan_res_t     sres;
  logic [CW-1:0] pick_idx, pos;
  logic          scan_clear;

  // request rounding
  logic [3:0]    lg;
  logic [17:0]   umask, in_need, in_fend;
  logic          fin;
  status_t       fin_st;
  logic [15:0]   fin_base;
  logic          lm, rm;
  logic [16:0]   cfg_mem;

  assign lg      = (unit_r > 4'(UNIT_LOG2_MAX)) ? 4'(UNIT_LOG2_MAX) : unit_r;
  assign umask   = (18'd1 << lg) - 18'd1;
  assign in_need = ({1'b0, in_item.request_bytes} + umask) & ~umask;
  assign in_fend = {2'b0, in_item.region_base} + in_need;
  assign lm      = sres.left_v &&
                   ({2'b0, sres.left_base} + {1'b0, sres.left_size} == {2'b0, base_r});
  assign rm      = sres.right_v && ({2'b0, sres.right_base} == fend_r);
  assign cfg_mem = (cfg_wdata > SPACE) ? SPACE : cfg_wdata;

  assign ctl.clear = scan_clear;
  assign ctl.cmd   = cmd_r;
  assign ctl.fit   = fit_r;
  assign ctl.need  = need_r;
  assign ctl.base  = base_r;
  assign ctl.fend  = fend_r;
  assign ctl.chk_v = chk_v_r;

  sfa_ram #(.WIDTH(EW), .DEPTH(MAX_SEGMENTS)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_wa),
    .wdata (ram_wd),
    .raddr (ram_ra),
    .rdata (ram_rd)
  );

  sfa_scan #(.IW(IW), .CW(CW)) u_scan (
    .clk      (clk),
    .ctl      (ctl),
    .idx      (chk_idx_r),
    .e_base   (ram_rd[ADDR_BITS-1:0]),
    .e_size   (ram_rd[EW-1:ADDR_BITS]),
    .res      (sres),
    .pick_idx (pick_idx),
    .pos      (pos)
  );

  always_comb begin
    state_nxt    = state_r;
    cmd_nxt      = cmd_r;
    base_nxt     = base_r;
    need_nxt     = need_r;
    fend_nxt     = fend_r;
    count_nxt    = count_r;
    fit_nxt      = fit_r;
    unit_nxt     = unit_r;
    mem_nxt      = mem_r;
    scan_idx_nxt = scan_idx_r;
    chk_v_nxt    = 1'b0;
    chk_idx_nxt  = chk_idx_r;
    sh_act_nxt   = sh_act_r;
    sh_up_nxt    = sh_up_r;
    sh_idx_nxt   = sh_idx_r;
    sh_lo_nxt    = sh_lo_r;
    wv_nxt       = 1'b0;
    wa_nxt       = wa_r;
    ram_we       = 1'b0;
    ram_wa       = '0;
    ram_wd       = '0;
    ram_ra       = '0;
    scan_clear   = 1'b0;
    fin          = 1'b0;
    fin_st       = ST_OK;
    fin_base     = base_r;

    case (state_r)
      S_INIT: begin
        // load the reset segment covering the whole space
        ram_we    = 1'b1;
        ram_wd    = {SPACE, 16'h0};
        state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (start) begin
          cmd_nxt  = cmd_t'(in_item.command);
          base_nxt = in_item.region_base;
          need_nxt = in_need;
          fend_nxt = in_fend;
          if (in_need == 18'd0 ||
              (in_item.command == CMD_ALLOC && in_need > {1'b0, mem_r}) ||
              (in_item.command == CMD_FREE && in_fend > {1'b0, mem_r})) begin
            fin    = 1'b1;
            fin_st = ST_INVALID;
          end else begin
            scan_clear   = 1'b1;
            scan_idx_nxt = '0;
            state_nxt    = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        // issue one read a beat, evaluate the previous read in the scan unit
        ram_ra      = scan_idx_r[IW-1:0];
        chk_idx_nxt = scan_idx_r[IW-1:0];
        if (scan_idx_r < count_r) begin
          chk_v_nxt    = 1'b1;
          scan_idx_nxt = scan_idx_r + CW'(1);
        end else if (!chk_v_r) begin
          state_nxt = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (cmd_r == CMD_ALLOC) begin
          if (!sres.found) begin
            fin       = 1'b1;
            fin_st    = ST_NO_SPACE;
            state_nxt = S_IDLE;
          end else begin
            base_nxt = sres.pick_base;
            fin_base = sres.pick_base;
            if ({1'b0, sres.pick_size} > need_r) begin
              // split: keep the upper remainder
              ram_we    = 1'b1;
              ram_wa    = pick_idx[IW-1:0];
              ram_wd    = {17'({1'b0, sres.pick_size} - need_r),
                           16'({2'b0, sres.pick_base} + need_r)};
              fin       = 1'b1;
              state_nxt = S_IDLE;
            end else begin
              sh_up_nxt  = 1'b0;
              sh_idx_nxt = pick_idx + CW'(1);
              sh_act_nxt = (pick_idx + CW'(1)) < count_r;
              state_nxt  = S_SHIFT;
            end
          end
        end else begin
          if (sres.overlap) begin
            fin       = 1'b1;
            fin_st    = ST_INVALID;
            state_nxt = S_IDLE;
          end else if (lm) begin
            // grow the left neighbor, absorbing the right one if it touches
            ram_we = 1'b1;
            ram_wa = IW'(pos - CW'(1));
            ram_wd = {17'({1'b0, sres.left_size} + need_r +
                          (rm ? {1'b0, sres.right_size} : 18'd0)), sres.left_base};
            if (rm) begin
              sh_up_nxt  = 1'b0;
              sh_idx_nxt = pos + CW'(1);
              sh_act_nxt = (pos + CW'(1)) < count_r;
              state_nxt  = S_SHIFT;
            end else begin
              fin       = 1'b1;
              state_nxt = S_IDLE;
            end
          end else if (rm) begin
            ram_we    = 1'b1;
            ram_wa    = pos[IW-1:0];
            ram_wd    = {17'({1'b0, sres.right_size} + need_r), base_r};
            fin       = 1'b1;
            state_nxt = S_IDLE;
          end else if (count_r >= CW'(MAX_SEGMENTS)) begin
            fin       = 1'b1;
            fin_st    = ST_FULL;
            state_nxt = S_IDLE;
          end else begin
            // open a hole at pos, moving the tail up from the top
            sh_up_nxt  = 1'b1;
            sh_lo_nxt  = pos;
            sh_idx_nxt = count_r - CW'(1);
            sh_act_nxt = count_r > pos;
            state_nxt  = S_SHIFT;
          end
        end
      end
      S_SHIFT: begin
        ram_ra = sh_idx_r[IW-1:0];
        if (sh_act_r) begin
          wv_nxt = 1'b1;
          if (sh_up_r) begin
            wa_nxt     = IW'(sh_idx_r + CW'(1));
            sh_idx_nxt = sh_idx_r - CW'(1);
            sh_act_nxt = sh_idx_r != sh_lo_r;
          end else begin
            wa_nxt     = IW'(sh_idx_r - CW'(1));
            sh_idx_nxt = sh_idx_r + CW'(1);
            sh_act_nxt = (sh_idx_r + CW'(1)) < count_r;
          end
        end
        if (wv_r) begin
          ram_we = 1'b1;
          ram_wa = wa_r;
          ram_wd = ram_rd;
        end else if (!sh_act_r) begin
          if (sh_up_r) begin
            ram_we    = 1'b1;
            ram_wa    = sh_lo_r[IW-1:0];
            ram_wd    = {need_r[16:0], base_r};
            count_nxt = count_r + CW'(1);
          end else begin
            count_nxt = count_r - CW'(1);
          end
          fin       = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // configuration writes must arrive only while idle; the block does not enforce it
    if (cfg_we) begin
      case (cfg_addr)
        CFG_FIT_MODE:  fit_nxt  = fit_t'(cfg_wdata[0]);
        CFG_UNIT_LOG2: unit_nxt = cfg_wdata[3:0];
        CFG_MEM_SIZE: begin
          mem_nxt   = cfg_mem;
          count_nxt = (cfg_mem != 17'd0) ? CW'(1) : CW'(0);
          ram_we    = 1'b1;
          ram_wa    = '0;
          ram_wd    = {cfg_mem, 16'h0};
        end
        default: begin
        end
      endcase
    end

    out_valid_nxt = fin;
    if (fin_st == ST_OK) begin
      out_item_nxt = '{status: ST_OK, granted_base: fin_base,
                       granted_size: need_r[16:0]};
    end else begin
      out_item_nxt = '{status: fin_st, granted_base: 16'h0, granted_size: 17'h0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_INIT;
      count_r     <= CW'(1);
      fit_r       <= FIT_BEST;
      unit_r      <= 4'd4;
      mem_r       <= SPACE;
      chk_v_r     <= 1'b0;
      sh_act_r    <= 1'b0;
      wv_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      fit_r       <= fit_nxt;
      unit_r      <= unit_nxt;
      mem_r       <= mem_nxt;
      chk_v_r     <= chk_v_nxt;
      sh_act_r    <= sh_act_nxt;
      wv_r        <= wv_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r      <= cmd_nxt;
    base_r     <= base_nxt;
    need_r     <= need_nxt;
    fend_r     <= fend_nxt;
    scan_idx_r <= scan_idx_nxt;
    chk_idx_r  <= chk_idx_nxt;
    sh_up_r    <= sh_up_nxt;
    sh_idx_r   <= sh_idx_nxt;
    sh_lo_r    <= sh_lo_nxt;
    wa_r       <= wa_nxt;
    out_item_r <= out_item_nxt;
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

// ----- tb/tb_segment_fit_allocator.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_segment_fit_allocator: self-checking bench for the segment fit allocator
// Drives allocate and free beats through the start/busy port, keeps its own
// model of the free-segment table, and checks each result strobe in order.
// ----------------------------------------------------------------------------
module tb_segment_fit_allocator;
  import sfa_pkg::*;

  localparam int TBL_DEPTH = 64;
  localparam int SPACE_MAX = 65536;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  in_t         in_item;
  logic        out_valid;
  out_t        out_item;
  logic        cfg_we;
  logic [1:0]  cfg_addr;
  logic [16:0] cfg_wdata;

  segment_fit_allocator dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_item(in_item),
    .out_valid(out_valid), .out_item(out_item), .cfg_we(cfg_we),
    .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
  );

  // Mirror of the block: registers and the sorted free-segment table.
  logic        fit_sel;
  int unsigned unit_lg;
  int unsigned mem_bytes;
  int unsigned seg_lo [TBL_DEPTH];
  int unsigned seg_len [TBL_DEPTH];
  int unsigned seg_cnt;

  // Regions currently handed out, used to build well-formed frees.
  int unsigned held_base [$];
  int unsigned held_size [$];

  in_t  beat_q [$];    // beats waiting for the driver
  out_t grant_q [$];   // expected result beats, oldest first
  int   err_cnt;
  int   idle_pct;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic report_mismatch(input string msg);
    $display("%0t ERROR: %s", $realtime, msg);
    err_cnt++;
  endtask

  function automatic int unsigned round_unit(input int unsigned bytes);
    int unsigned lg;
    int unsigned u;
    lg = (unit_lg > UNIT_LOG2_MAX) ? UNIT_LOG2_MAX : unit_lg;
    u  = 1 << lg;
    return (bytes + u - 1) & ~(u - 1);
  endfunction

  function automatic void reload_table();
    for (int i = 0; i < TBL_DEPTH; i++) begin
      seg_lo[i]  = 0;
      seg_len[i] = 0;
    end
    seg_cnt = (mem_bytes == 0) ? 0 : 1;
    seg_len[0] = mem_bytes;
    held_base.delete();
    held_size.delete();
  endfunction

  function automatic void apply_cfg(input logic [1:0] idx, input int unsigned val);
    case (idx)
      CFG_FIT_MODE:  fit_sel = val[0];
      CFG_UNIT_LOG2: unit_lg = val & 'hF;
      CFG_MEM_SIZE: begin
        mem_bytes = ((val & 'h1FFFF) > SPACE_MAX) ? SPACE_MAX : (val & 'h1FFFF);
        reload_table();
      end
      default: ;
    endcase
  endfunction

  function automatic void drop_seg(input int unsigned k);
    for (int unsigned i = k; i + 1 < seg_cnt; i++) begin
      seg_lo[i]  = seg_lo[i + 1];
      seg_len[i] = seg_len[i + 1];
    end
    seg_cnt--;
    seg_lo[seg_cnt]  = 0;
    seg_len[seg_cnt] = 0;
  endfunction

  // Work out the grant for one accepted beat and update the table mirror.
  function automatic out_t fit_and_update(input in_t it);
    out_t        r;
    int unsigned len, fend, pos, pick;
    bit          found, left, right;
    r = '0;
    len = round_unit(it.request_bytes);
    if (it.command == CMD_ALLOC) begin
      found = 0;
      pick  = 0;
      if (len == 0 || len > mem_bytes) begin
        r.status = ST_INVALID;
        return r;
      end
      for (int unsigned i = 0; i < seg_cnt; i++) begin
        if (seg_len[i] < len) continue;
        if (!found) begin
          pick  = i;
          found = 1;
        end else if (fit_sel == FIT_BEST ? seg_len[i] < seg_len[pick]
                                         : seg_len[i] > seg_len[pick]) begin
          pick = i;
        end
      end
      if (!found) begin
        r.status = ST_NO_SPACE;
        return r;
      end
      r.status       = ST_OK;
      r.granted_base = 16'(seg_lo[pick]);
      r.granted_size = 17'(len);
      held_base.insert(held_base.size(), seg_lo[pick]);
      held_size.insert(held_size.size(), len);
      if (seg_len[pick] > len) begin
        seg_lo[pick]  += len;
        seg_len[pick] -= len;
      end else begin
        drop_seg(pick);
      end
      return r;
    end
    // free
    fend = it.region_base + len;
    pos  = 0;
    if (len == 0 || fend > mem_bytes) begin
      r.status = ST_INVALID;
      return r;
    end
    for (int unsigned i = 0; i < seg_cnt; i++) begin
      if (it.region_base < seg_lo[i] + seg_len[i] && seg_lo[i] < fend) begin
        r.status = ST_INVALID;
        return r;
      end
      if (seg_lo[i] < it.region_base) pos = i + 1;
    end
    left  = pos > 0 && seg_lo[pos - 1] + seg_len[pos - 1] == it.region_base;
    right = pos < seg_cnt && seg_lo[pos] == fend;
    if (left && right) begin
      seg_len[pos - 1] += len + seg_len[pos];
      drop_seg(pos);
    end else if (left) begin
      seg_len[pos - 1] += len;
    end else if (right) begin
      seg_lo[pos]   = it.region_base;
      seg_len[pos] += len;
    end else begin
      if (seg_cnt >= TBL_DEPTH) begin
        r.status = ST_FULL;
        return r;
      end
      for (int unsigned i = seg_cnt; i > pos; i--) begin
        seg_lo[i]  = seg_lo[i - 1];
        seg_len[i] = seg_len[i - 1];
      end
      seg_lo[pos]  = it.region_base;
      seg_len[pos] = len;
      seg_cnt++;
    end
    r.status       = ST_OK;
    r.granted_base = it.region_base;
    r.granted_size = 17'(len);
    return r;
  endfunction

  // Driver: change inputs on the falling edge; offer the head beat until accepted, with random idle gaps.
  always @(negedge clk) begin
    if (!rst_n) begin
      start   <= 1'b0;
      in_item <= '0;
    end else if (beat_q.size() > 0 && $urandom_range(99) >= idle_pct) begin
      start   <= 1'b1;
      in_item <= beat_q[0];
    end else begin
      start   <= 1'b0;
    end
  end

  // Monitor: take accepted beats into the mirror, then check any result.
  always @(posedge clk) begin
    out_t want;
    if (rst_n && start && !busy) begin
      grant_q.insert(grant_q.size(), fit_and_update(in_item));
      void'(beat_q.pop_front());
    end
    if (rst_n && out_valid) begin
      if (grant_q.size() == 0) begin
        report_mismatch("result strobe with no request outstanding");
      end else begin
        want = grant_q.pop_front();
        if (out_item.status !== want.status)
          report_mismatch($sformatf("status got %0d want %0d",
                                    out_item.status, want.status));
        if (out_item.granted_base !== want.granted_base)
          report_mismatch($sformatf("granted_base got %0h want %0h",
                                    out_item.granted_base, want.granted_base));
        if (out_item.granted_size !== want.granted_size)
          report_mismatch($sformatf("granted_size got %0h want %0h",
                                    out_item.granted_size, want.granted_size));
      end
    end
  end

  // Queue one beat and wait until the driver has handed it over, so the
  // generator always sees an up-to-date list of held regions.
  task automatic send_beat(input cmd_t c, input int unsigned bytes,
                           input int unsigned base);
    in_t it;
    it.command       = c;
    it.request_bytes = bytes[16:0];
    it.region_base   = base[15:0];
    beat_q.insert(beat_q.size(), it);
    while (beat_q.size() > 0) @(posedge clk);
  endtask

  // Hold off until every expected result is in, then let the scan settle.
  task automatic wait_quiet();
    while (beat_q.size() > 0 || grant_q.size() > 0) @(posedge clk);
    repeat (150) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input int unsigned val);
    wait_quiet();
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val[16:0];
    @(posedge clk);
    apply_cfg(idx, val);
    @(negedge clk);
    cfg_we    <= 1'b0;
    repeat (4) @(posedge clk);
  endtask

  // One random beat: mostly well-formed allocs and frees of held regions.
  task automatic random_beat();
    int unsigned r, k, lg, sz;
    r  = $urandom_range(99);
    lg = (unit_lg > UNIT_LOG2_MAX) ? UNIT_LOG2_MAX : unit_lg;
    if (r < 50) begin
      sz = $urandom_range(1, (1 << lg) * 4);
      send_beat(CMD_ALLOC, sz, $urandom_range(65535));
    end else if (r < 56) begin
      send_beat(CMD_ALLOC, $urandom_range(1, mem_bytes / 3 + 1), 0);
    end else if (r < 88 && held_base.size() > 0) begin
      k  = $urandom_range(held_base.size() - 1);
      sz = held_size[k];
      // Now and then release only the front part of the region.
      if ($urandom_range(5) == 0) sz = $urandom_range(1, sz);
      send_beat(CMD_FREE, sz, held_base[k]);
      held_base.delete(k);
      held_size.delete(k);
    end else if (r < 94) begin
      send_beat(CMD_FREE, $urandom_range(131071), $urandom_range(65535));
    end else begin
      send_beat(CMD_ALLOC, $urandom_range(131071), $urandom_range(65535));
    end
  endtask

  int unsigned ph_fit  [7] = '{0, 1, 0, 1, 0, 1, 0};
  int unsigned ph_unit [7] = '{4, 0, 12, 15, 0, 6, 3};
  int unsigned ph_mem  [7] = '{65536, 256, 65536, 100000, 0, 1, 4000};
  int          ph_idle [7] = '{0, 71, 26, 0, 71, 26, 0};

  initial begin
    err_cnt   = 0;
    idle_pct  = 0;
    rst_n     = 1'b0;
    cfg_we    = 1'b0;
    cfg_addr  = '0;
    cfg_wdata = '0;
    fit_sel   = FIT_BEST;
    unit_lg   = 4;
    mem_bytes = SPACE_MAX;
    reload_table();
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    repeat (4) @(posedge clk);

    // Directed: reset table, zero and oversized requests, no space,
    // double free, out-of-range free, merges on the right side and on both sides.
    send_beat(CMD_ALLOC, 0, 0);
    send_beat(CMD_ALLOC, 131071, 16'hFFFF);
    send_beat(CMD_ALLOC, 65536, 0);
    send_beat(CMD_ALLOC, 1, 0);
    send_beat(CMD_FREE, 65536, 0);
    send_beat(CMD_FREE, 16, 0);
    send_beat(CMD_FREE, 131071, 16'hFFFF);
    send_beat(CMD_FREE, 0, 100);
    send_beat(CMD_ALLOC, 16, 0);
    send_beat(CMD_ALLOC, 17, 0);
    send_beat(CMD_ALLOC, 16, 0);
    send_beat(CMD_FREE, 16, 0);
    send_beat(CMD_FREE, 16, 48);
    send_beat(CMD_FREE, 32, 16);
    send_beat(CMD_ALLOC, 1, 0);
    send_beat(CMD_ALLOC, 1000, 0);
    send_beat(CMD_FREE, 16, 0);
    send_beat(CMD_FREE, 16, 16'hFFF0);
    held_base.delete();
    held_size.delete();
    wait_quiet();

    for (int p = 0; p < 7; p++) begin
      write_reg(CFG_FIT_MODE, ph_fit[p]);
      write_reg(CFG_UNIT_LOG2, ph_unit[p]);
      write_reg(CFG_MEM_SIZE, ph_mem[p]);
      idle_pct = ph_idle[p];
      if (p == 1) begin
        // Fragment a small space byte by byte until the table fills up.
        for (int i = 0; i < 256; i++) send_beat(CMD_ALLOC, 1, 0);
        for (int i = 0; i < 256; i += 2) send_beat(CMD_FREE, 1, i);
        held_base.delete();
        held_size.delete();
      end
      for (int i = 0; i < 200; i++) begin
        random_beat();
        if (i == 100) wait_quiet();
      end
    end

    wait_quiet();
    if (grant_q.size() != 0) report_mismatch("results still outstanding at end");
    if (err_cnt == 0) begin
      $display("tb_segment_fit_allocator: PASS");
    end else begin
      $display("tb_segment_fit_allocator: FAIL");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #20ms;
    $display("tb_segment_fit_allocator: FAIL");
    $finish;
  end

endmodule
